// ===== src/dei_pkg.sv =====
// shared constants for the daily energy integrator
package dei_pkg;

  // field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DAY_W    = 9;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned CUR_W    = 32;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned YIELD_W  = 16;
  localparam int unsigned TOTAL_W  = 63;
  localparam int unsigned GAP_W    = 16;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W  = CUR_W + VOLT_W;
  localparam int unsigned MUL_B_W  = GAP_W;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes, decoded from the word address bit
  localparam logic REG_TIME_FLOOR = 1'b0;
  localparam logic REG_MAX_GAP    = 1'b1;

  // command codes
  localparam logic CMD_BATTERY = 1'b0;
  localparam logic CMD_YIELD   = 1'b1;

  // register reset values
  localparam logic [TIME_W-1:0] FLOOR_RESET = 32'd1000000000;
  localparam logic [GAP_W-1:0]  GAP_RESET   = 16'd600;

  // saturation ceiling of the totals
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ===== src/dei_ifs.sv =====
// request channel interfaces for samples and results

interface dei_in_if
  import dei_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [TIME_W-1:0]          timestamp;
  logic [DAY_W-1:0]           day_index;
  logic [YEAR_W-1:0]          calendar_year;
  logic signed [CUR_W-1:0]    current_milliamps;
  logic [VOLT_W-1:0]          voltage_centivolts;
  logic [YIELD_W-1:0]         yield_report;

  modport source (
    output valid, cmd, timestamp, day_index, calendar_year,
           current_milliamps, voltage_centivolts, yield_report,
    input  ready
  );
  modport sink (
    input  valid, cmd, timestamp, day_index, calendar_year,
           current_milliamps, voltage_centivolts, yield_report,
    output ready
  );
endinterface

interface dei_out_if
  import dei_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [TOTAL_W-1:0]   charge_energy;
  logic [TOTAL_W-1:0]   load_energy;
  logic [YIELD_W-1:0]   solar_yield;
  logic                 yield_preferred;
  logic                 fresh;

  modport source (
    output valid, charge_energy, load_energy, solar_yield, yield_preferred, fresh,
    input  ready
  );
  modport sink (
    input  valid, charge_energy, load_energy, solar_yield, yield_preferred, fresh,
    output ready
  );
endinterface

// ===== src/daily_energy_integrator_core.sv =====
// daily charge and load energy integrator with a shared multiplier sequencer
//
// Usage:
//   in_ch  carries battery samples (cmd 0) and solar yield reports (cmd 1).
//   out_ch returns one result per request: both daily totals in 10 uJ units,
//   the stored yield, the yield preference flag and the freshness flag.
//   The APB-style port writes the timestamp floor (byte 0) and the gap limit
//   (byte 4); the user must write it only while idle; the block does not check.
// Timing:
//   A request is taken only while the sequencer is idle. For a yield report,
//   an ignored sample or a sample without integration the request goes from
//   evaluation to the final step; an integrated sample passes S_MUL1, S_MUL2
//   and S_ACC first, as the energy volt * |current| * gap goes through one
//   48x16 multiplier twice and then one 63-bit saturating add.
// Reset:
//   rst_n (synchronous, active low) clears the totals, the day, the last
//   sample time, the stored yield and the flags, and restores both
//   configuration registers to their defaults.
// Stall:
//   A finished result sits in the output register; the next request is
//   still taken, and its result waits in the final step until out_ch.ready.
module daily_energy_integrator_core
  import dei_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dei_in_if.sink                in_ch,
  dei_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [TIME_W-1:0] floor_r, floor_nxt;
  logic [GAP_W-1:0]  max_gap_r, max_gap_nxt;

  // architectural state
  logic [TOTAL_W-1:0] charge_total_r, charge_total_nxt;
  logic [TOTAL_W-1:0] load_total_r, load_total_nxt;
  logic [DAY_W-1:0]   stored_day_r, stored_day_nxt;
  logic [YEAR_W-1:0]  stored_year_r, stored_year_nxt;
  logic               day_known_r, day_known_nxt;
  logic [TIME_W-1:0]  last_time_r, last_time_nxt;
  logic               have_sample_r, have_sample_nxt;
  logic [YIELD_W-1:0] stored_yield_r, stored_yield_nxt;

  // latched request
  logic               cmd_r, cmd_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [VOLT_W-1:0]  volt_r, volt_nxt;
  logic [YIELD_W-1:0] yield_r, yield_nxt;

  // datapath registers
  logic               neg_r, neg_nxt;
  logic [CUR_W-1:0]   mag_r, mag_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [MUL_A_W-1:0] prod_r, prod_nxt;
  logic [TOTAL_W-1:0] energy_r, energy_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_charge_r, out_charge_nxt;
  logic [TOTAL_W-1:0] out_load_r, out_load_nxt;
  logic [YIELD_W-1:0] out_yield_r, out_yield_nxt;
  logic               out_pref_r, out_pref_nxt;
  logic               out_fresh_r, out_fresh_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // combinational helpers
  logic                 in_fire;
  logic                 cfg_wr;
  logic [TIME_W-1:0]    gap_full;
  logic                 do_integrate;
  logic                 new_day;
  logic                 to_charge;
  logic [TOTAL_W-1:0]   acc_base;
  logic [TOTAL_W:0]     acc_sum;
  logic [TOTAL_W-1:0]   acc_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.charge_energy   = out_charge_r;
  assign out_ch.load_energy     = out_load_r;
  assign out_ch.solar_yield     = out_yield_r;
  assign out_ch.yield_preferred = out_pref_r;
  assign out_ch.fresh           = out_fresh_r;

  // config port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_TIME_FLOOR: prdata = floor_r;
      REG_MAX_GAP:    prdata = {{(CFG_DATA_W-GAP_W){1'b0}}, max_gap_r};
      default:        prdata = '0;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {{(MUL_A_W-CUR_W){1'b0}}, mag_r};
      mul_b = volt_r;
    end else begin
      mul_a = prod_r;
      mul_b = gap_r;
    end
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // gap and day checks against the stored sample
  assign gap_full     = now_r - last_time_r;
  assign do_integrate = have_sample_r && (now_r > last_time_r) &&
                        (gap_full[TIME_W-1:GAP_W] == '0) &&
                        (gap_full[GAP_W-1:0] < max_gap_r);
  assign new_day      = !day_known_r || (day_r != stored_day_r) ||
                        (year_r != stored_year_r);

  // saturating accumulate into the selected total
  assign to_charge = !neg_r && (energy_r != '0);
  assign acc_base  = to_charge ? charge_total_r : load_total_r;
  assign acc_sum   = {1'b0, acc_base} + {1'b0, energy_r};
  assign acc_sat   = acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];

  // sequencer next state
  always_comb begin
    state_nxt        = state_r;
    floor_nxt        = floor_r;
    max_gap_nxt      = max_gap_r;
    charge_total_nxt = charge_total_r;
    load_total_nxt   = load_total_r;
    stored_day_nxt   = stored_day_r;
    stored_year_nxt  = stored_year_r;
    day_known_nxt    = day_known_r;
    last_time_nxt    = last_time_r;
    have_sample_nxt  = have_sample_r;
    stored_yield_nxt = stored_yield_r;
    cmd_nxt          = cmd_r;
    now_nxt          = now_r;
    day_nxt          = day_r;
    year_nxt         = year_r;
    cur_nxt          = cur_r;
    volt_nxt         = volt_r;
    yield_nxt        = yield_r;
    neg_nxt          = neg_r;
    mag_nxt          = mag_r;
    gap_nxt          = gap_r;
    prod_nxt         = prod_r;
    energy_nxt       = energy_r;
    out_valid_nxt    = out_valid_r;
    out_charge_nxt   = out_charge_r;
    out_load_nxt     = out_load_r;
    out_yield_nxt    = out_yield_r;
    out_pref_nxt     = out_pref_r;
    out_fresh_nxt    = out_fresh_r;

    // configuration writes
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_TIME_FLOOR: floor_nxt = pwdata;
        REG_MAX_GAP:    max_gap_nxt = pwdata[GAP_W-1:0];
        default:        floor_nxt = floor_r;
      endcase
    end

    // output register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.cmd;
          now_nxt   = in_ch.timestamp;
          day_nxt   = in_ch.day_index;
          year_nxt  = in_ch.calendar_year;
          cur_nxt   = in_ch.current_milliamps;
          volt_nxt  = in_ch.voltage_centivolts;
          yield_nxt = in_ch.yield_report;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_YIELD) begin
          stored_yield_nxt = yield_r;
        end else if (now_r >= floor_r) begin
          if (new_day) begin
            charge_total_nxt = '0;
            load_total_nxt   = '0;
            stored_day_nxt   = day_r;
            stored_year_nxt  = year_r;
            day_known_nxt    = 1'b1;
          end
          neg_nxt         = cur_r[CUR_W-1];
          mag_nxt         = cur_r[CUR_W-1] ? (~cur_r + 1'b1) : cur_r;
          gap_nxt         = gap_full[GAP_W-1:0];
          last_time_nxt   = now_r;
          have_sample_nxt = 1'b1;
          if (do_integrate) begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod_nxt  = mul_p[MUL_A_W-1:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        energy_nxt = mul_p[TOTAL_W-1:0];
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        if (to_charge) begin
          charge_total_nxt = acc_sat;
        end else begin
          load_total_nxt = acc_sat;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_charge_nxt = charge_total_r;
          out_load_nxt   = load_total_r;
          out_yield_nxt  = stored_yield_r;
          out_pref_nxt   = (stored_yield_r != '0);
          out_fresh_nxt  = have_sample_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      floor_r        <= FLOOR_RESET;
      max_gap_r      <= GAP_RESET;
      charge_total_r <= '0;
      load_total_r   <= '0;
      stored_day_r   <= '0;
      stored_year_r  <= '0;
      day_known_r    <= 1'b0;
      last_time_r    <= '0;
      have_sample_r  <= 1'b0;
      stored_yield_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      floor_r        <= floor_nxt;
      max_gap_r      <= max_gap_nxt;
      charge_total_r <= charge_total_nxt;
      load_total_r   <= load_total_nxt;
      stored_day_r   <= stored_day_nxt;
      stored_year_r  <= stored_year_nxt;
      day_known_r    <= day_known_nxt;
      last_time_r    <= last_time_nxt;
      have_sample_r  <= have_sample_nxt;
      stored_yield_r <= stored_yield_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    now_r        <= now_nxt;
    day_r        <= day_nxt;
    year_r       <= year_nxt;
    cur_r        <= cur_nxt;
    volt_r       <= volt_nxt;
    yield_r      <= yield_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    gap_r        <= gap_nxt;
    prod_r       <= prod_nxt;
    energy_r     <= energy_nxt;
    out_charge_r <= out_charge_nxt;
    out_load_r   <= out_load_nxt;
    out_yield_r  <= out_yield_nxt;
    out_pref_r   <= out_pref_nxt;
    out_fresh_r  <= out_fresh_nxt;
  end

`ifndef SYNTH
  // an accepted request always goes to evaluation next
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EVAL)
    else $error("accepted request did not enter evaluation");

  // second multiply pass always follows the first
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL2 |-> $past(state_r) == S_MUL1)
    else $error("second multiply without first");

  // totals move only on a day clear or an accumulate step
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EVAL && state_r != S_ACC) |=>
      $stable(charge_total_r) && $stable(load_total_r))
    else $error("totals changed outside evaluation or accumulate");

  // once a sample is taken the block stays fresh until reset
  a_fresh_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_sample_r |=> have_sample_r)
    else $error("fresh flag dropped");

  // a new result only comes out of the final step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside final step");
`endif

endmodule
